@@ rtl/core/tdsm_pkg.sv @@
// Shared types and codes for the table-driven state machine.
// No dependencies; imported by tdsm_cell, table_driven_state_machine_top and the testbench.
`default_nettype none

package tdsm_pkg;

    // Item kinds carried on the input tuser
    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ACTIVE_ROWS   = 1'b0;
    localparam logic CFG_INITIAL_STATE = 1'b1;

    // One transition row as held by a cell
    typedef struct packed {
        logic [7:0] from_state;
        logic [7:0] event_code;
        logic [7:0] to_state;
        logic [7:0] action;
        logic       has_action;
    } row_t;

    // Search token passed down the cell chain
    typedef struct packed {
        logic       hit;
        logic [7:0] to_state;
        logic [7:0] action;
        logic       has_action;
    } token_t;

    // One result item
    typedef struct packed {
        logic [31:0] reject_total;
        logic        action_valid;
        logic [7:0]  action_code;
        logic [7:0]  present_state;
        logic        rejected;
        logic        fired;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/tdsm_cell.sv @@
// One cell of the transition-table chain: holds one row and one token stage.
// Depends on tdsm_pkg.
`default_nettype none

module tdsm_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire tdsm_pkg::row_t wr_row,
    input  wire logic           scan_en,
    input  wire logic [7:0]     key_state,
    input  wire logic [7:0]     key_event,
    input  wire logic           tok_in_valid,
    input  wire tdsm_pkg::token_t tok_in,
    output logic                tok_out_valid,
    output tdsm_pkg::token_t    tok_out
);
    import tdsm_pkg::*;

    row_t   row_reg;
    logic   tok_valid_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   match;

    // first matching row wins: later cells skip once hit is set
    assign match = tok_in_valid && !tok_in.hit && scan_en &&
                   (row_reg.from_state == key_state) &&
                   (row_reg.event_code == key_event);

    always_comb
    begin
        tok_next = tok_in;
        if (match)
        begin
            tok_next.hit        = 1'b1;
            tok_next.to_state   = row_reg.to_state;
            tok_next.has_action = row_reg.has_action;
            tok_next.action     = row_reg.has_action ? row_reg.action : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_reg <= wr_row;
        end
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

`default_nettype wire

@@ rtl/core/table_driven_state_machine_top.sv @@
// Programmable transition-table state machine, top level.
// Depends on tdsm_pkg and tdsm_cell.
`default_nettype none

// The block runs a state machine whose transitions live in a table of
// MAX_ROWS rows, loaded at run time by row-write items. An event item walks
// a search token down a chain of MAX_ROWS cells, one cell per clock; each
// cell holds one row and the first active row whose from-state and event
// match the current state and the event wins. The event key is registered
// at acceptance and the token enters the chain on the following cycle.
// When the token leaves the last cell, the result is staged in a result
// register and then moved to the output register; reset, row-write and
// unknown items are staged at acceptance and moved on the same way. One
// item is in flight at a time; the result sits in an output register, so
// the next item is accepted while it waits to be taken. A result still
// held by a stalled output delays the move of the next result, and with
// it the next acceptance. An unmatched event bumps a wrapping 32-bit
// reject counter. Rows that were never written must not be reached by a
// scan. Configuration writes (active_rows, initial_state) are meant for
// idle periods only; a new initial_state applies at the next reset item.

module table_driven_state_machine_top #(
    parameter int MAX_ROWS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] event_code, [11:8] row_index, [19:12] row_from, [27:20] row_event,
    // [35:28] row_to, [43:36] row_action, [44] row_has_action, rest zero
    input  wire logic [47:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_tuser,
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] fired, [1] rejected, [9:2] present_state, [17:10] action_code,
    // [18] action_valid, [50:19] reject_total, rest zero
    output logic [55:0]      m_tdata
);
    import tdsm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // input field split
    logic [1:0] in_kind;
    logic [7:0] in_event;
    logic [3:0] in_row_index;
    row_t       in_row;

    assign in_kind              = s_tuser;
    assign in_event             = s_tdata[7:0];
    assign in_row_index         = s_tdata[11:8];
    assign in_row.from_state    = s_tdata[19:12];
    assign in_row.event_code    = s_tdata[27:20];
    assign in_row.to_state      = s_tdata[35:28];
    assign in_row.action        = s_tdata[43:36];
    assign in_row.has_action    = s_tdata[44];

    // registers
    logic [1:0]  state_reg, state_next;
    logic [4:0]  active_rows_reg;
    logic [7:0]  initial_state_reg;
    logic [7:0]  cur_state_reg, cur_state_next;
    logic [31:0] reject_cnt_reg, reject_cnt_next;
    logic [7:0]  key_event_reg, key_event_next;
    result_t     res_reg, res_next;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic        launch_reg;

    logic accept;
    logic launch;
    logic row_write;
    logic out_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign launch    = accept && (in_kind == KIND_EVENT);
    assign row_write = accept && (in_kind == KIND_WRITE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // cell chain
    logic   tok_valid [0:MAX_ROWS];
    token_t tok       [0:MAX_ROWS];

    // token enters once the event key is in key_event_reg
    assign tok_valid[0]      = launch_reg;
    assign tok[0].hit        = 1'b0;
    assign tok[0].to_state   = 8'd0;
    assign tok[0].action     = 8'd0;
    assign tok[0].has_action = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ROWS; gi++)
        begin : g_cell
            logic cell_wr;
            logic cell_scan;

            // rows past the 4-bit index range are never written
            assign cell_wr   = row_write && (32'(in_row_index) == 32'(gi));
            // cells past active_rows do not take part in the search
            assign cell_scan = (32'(gi) < 32'(active_rows_reg));

            tdsm_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .wr_en        (cell_wr),
                .wr_row       (in_row),
                .scan_en      (cell_scan),
                .key_state    (cur_state_reg),
                .key_event    (key_event_reg),
                .tok_in_valid (tok_valid[gi]),
                .tok_in       (tok[gi]),
                .tok_out_valid(tok_valid[gi+1]),
                .tok_out      (tok[gi+1])
            );
        end
    endgenerate

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_state_next  = cur_state_reg;
        reject_cnt_next = reject_cnt_reg;
        key_event_next  = key_event_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.fired         = 1'b0;
                    res_next.rejected      = 1'b0;
                    res_next.action_code   = 8'd0;
                    res_next.action_valid  = 1'b0;
                    res_next.present_state = cur_state_reg;
                    res_next.reject_total  = reject_cnt_reg;
                    state_next             = ST_DONE;
                    unique case (in_kind)
                        KIND_EVENT:
                        begin
                            key_event_next = in_event;
                            state_next     = ST_SCAN;
                        end
                        KIND_RESET:
                        begin
                            cur_state_next         = initial_state_reg;
                            res_next.present_state = initial_state_reg;
                        end
                        default:
                        begin
                            // row write handled by the cells; unknown kind is a no-op
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (tok_valid[MAX_ROWS])
                begin
                    state_next = ST_DONE;
                    if (tok[MAX_ROWS].hit)
                    begin
                        cur_state_next         = tok[MAX_ROWS].to_state;
                        res_next.fired         = 1'b1;
                        res_next.rejected      = 1'b0;
                        res_next.present_state = tok[MAX_ROWS].to_state;
                        res_next.action_code   = tok[MAX_ROWS].action;
                        res_next.action_valid  = tok[MAX_ROWS].has_action;
                        res_next.reject_total  = reject_cnt_reg;
                    end
                    else
                    begin
                        reject_cnt_next        = reject_cnt_reg + 32'd1;
                        res_next.fired         = 1'b0;
                        res_next.rejected      = 1'b1;
                        res_next.present_state = cur_state_reg;
                        res_next.action_code   = 8'd0;
                        res_next.action_valid  = 1'b0;
                        res_next.reject_total  = reject_cnt_reg + 32'd1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            active_rows_reg   <= 5'd1;
            initial_state_reg <= 8'd0;
            cur_state_reg     <= 8'd0;
            reject_cnt_reg    <= 32'd0;
            out_valid_reg     <= 1'b0;
            launch_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_state_reg  <= cur_state_next;
            reject_cnt_reg <= reject_cnt_next;
            out_valid_reg  <= out_valid_next;
            launch_reg     <= launch;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ACTIVE_ROWS:   active_rows_reg   <= cfg_data[4:0];
                    CFG_INITIAL_STATE: initial_state_reg <= cfg_data;
                    default:           active_rows_reg   <= active_rows_reg;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        key_event_reg <= key_event_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};

endmodule

`default_nettype wire

@@ tb/tb_table_driven_state_machine_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for table_driven_state_machine_top: a directed table of items,
// then random phases under several register settings, checked by an in-bench predictor or hand-written expectations.
// Depends on tdsm_pkg and the block's RTL; reads no files.

module tb_table_driven_state_machine_top;
    import tdsm_pkg::*;

    localparam int ROWS = 16;
    localparam logic [1:0] KIND_SPARE = 2'd3;   // unused kind, must change nothing
    localparam int SETTLE = ROWS + 4;           // longest item latency plus margin
    localparam int NUM_PHASES = 6;

    // One line of the directed plan: either a register write or an item,
    // optionally with a hand-written expected result.
    typedef struct {
        bit          is_cfg;
        logic        cfg_sel;
        logic [7:0]  cfg_val;
        logic [1:0]  kind;
        logic [47:0] data;
        bit          typed;
        result_t     want;
    } plan_step_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    // [7:0] event_code, [11:8] row_index, [19:12] row_from, [27:20] row_event,
    // [35:28] row_to, [43:36] row_action, [44] row_has_action, rest zero
    logic [47:0] s_tdata;
    // [1:0] kind
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    // [0] fired, [1] rejected, [9:2] present_state, [17:10] action_code,
    // [18] action_valid, [50:19] reject_total, rest zero
    logic [55:0] m_tdata;

    table_driven_state_machine_top #(.MAX_ROWS(ROWS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the table, machine state, counter
    // and registers.
    // ------------------------------------------------------------------
    row_t        fsm_tab [ROWS];
    logic [7:0]  cur_state;
    logic [31:0] reject_cnt;
    logic [4:0]  cfg_rows;
    logic [7:0]  cfg_init;

    result_t     pending_results [$];   // oldest expectation at the front

    // Driver side-band: a hand-written expectation for the item on the bus
    bit          drv_typed;
    result_t     drv_want;

    // Pools that make random rows chain into each other
    logic [7:0]  st_pool [4];
    logic [7:0]  ev_pool [4];

    bit          idle_on;
    int          stall_left;
    int          errors;
    int          n_items, n_fired, n_rejected, n_writes, n_checked, n_settings;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // Advance the predicted machine by one item and return its result.
    function automatic result_t fsm_advance(input logic [1:0] kind, input logic [47:0] d);
        result_t r;
        int      n;
        bit      hit;
        r   = '0;
        hit = 1'b0;
        case (kind)
            KIND_EVENT: begin
                // scan saturates at the table depth; zero rows rejects everything
                n = (cfg_rows > ROWS) ? ROWS : int'(cfg_rows);
                for (int i = 0; i < n && !hit; i++) begin
                    if (fsm_tab[i].from_state == cur_state && fsm_tab[i].event_code == d[7:0]) begin
                        hit       = 1'b1;
                        cur_state = fsm_tab[i].to_state;
                        r.fired   = 1'b1;
                        if (fsm_tab[i].has_action) begin
                            r.action_valid = 1'b1;
                            r.action_code  = fsm_tab[i].action;
                        end
                    end
                end
                if (!hit) begin
                    r.rejected = 1'b1;
                    reject_cnt = reject_cnt + 32'd1;
                end
            end
            KIND_RESET: cur_state = cfg_init;
            KIND_WRITE: fsm_tab[d[11:8]] = {d[19:12], d[27:20], d[35:28], d[43:36], d[44]};
            default: ;
        endcase
        r.present_state = cur_state;
        r.reject_total  = reject_cnt;
        return r;
    endfunction

    // Mostly an event that some searched row accepts from the present state,
    // so the machine keeps walking; otherwise a pool or random event.
    function automatic logic [7:0] pick_event();
        logic [7:0] cand [$];
        int         n;
        n = (cfg_rows > ROWS) ? ROWS : int'(cfg_rows);
        for (int i = 0; i < n; i++)
            if (fsm_tab[i].from_state == cur_state)
                cand.push_back(fsm_tab[i].event_code);
        if (cand.size() != 0 && $urandom_range(0, 99) < 75)
            return cand[$urandom_range(0, cand.size() - 1)];
        if ($urandom_range(0, 1) == 1)
            return ev_pool[$urandom_range(0, 3)];
        return 8'($urandom);
    endfunction

    function automatic logic [47:0] noise();
        return {3'b000, 13'($urandom), $urandom};
    endfunction

    function automatic logic [47:0] row_bits(input logic [3:0] idx, input logic [7:0] from_st,
                                             input logic [7:0] ev, input logic [7:0] to_st,
                                             input logic [7:0] act, input logic has);
        return {3'b000, has, act, to_st, ev, from_st, idx, 8'h00};
    endfunction

    function automatic logic [47:0] rand_row(input logic [3:0] idx);
        logic [7:0] f, e, t;
        f = ($urandom_range(0, 9) < 8) ? st_pool[$urandom_range(0, 3)] : 8'($urandom);
        t = ($urandom_range(0, 9) < 8) ? st_pool[$urandom_range(0, 3)] : 8'($urandom);
        e = ($urandom_range(0, 9) < 8) ? ev_pool[$urandom_range(0, 3)] : 8'($urandom);
        return row_bits(idx, f, e, t, 8'($urandom), 1'($urandom));
    endfunction

    function automatic result_t res(input bit f, input bit rj, input logic [7:0] st,
                                    input logic [7:0] ac, input bit av, input logic [31:0] tot);
        result_t r;
        r = '0;
        r.fired         = f;
        r.rejected      = rj;
        r.present_state = st;
        r.action_code   = ac;
        r.action_valid  = av;
        r.reject_total  = tot;
        return r;
    endfunction

    function automatic plan_step_t do_cfg(input logic sel, input logic [7:0] val);
        plan_step_t s;
        s = '{default: '0};
        s.is_cfg  = 1'b1;
        s.cfg_sel = sel;
        s.cfg_val = val;
        return s;
    endfunction

    function automatic plan_step_t do_item(input logic [1:0] kind, input logic [47:0] data);
        plan_step_t s;
        s = '{default: '0};
        s.kind = kind;
        s.data = data;
        return s;
    endfunction

    function automatic plan_step_t do_check(input logic [1:0] kind, input logic [47:0] data,
                                            input result_t want);
        plan_step_t s;
        s = do_item(kind, data);
        s.typed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    task automatic match_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
        end
    endtask

    // Offer one item; returns at the falling edge after it was taken.
    // tvalid stays high so a following item goes out back to back.
    task automatic offer(input logic [1:0] kind, input logic [47:0] data,
                         input bit typed, input result_t want);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid  = 1'b1;
        s_tuser   = kind;
        s_tdata   = data;
        drv_typed = typed;
        drv_want  = want;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Register writes only with nothing in flight: drain, let the chain settle, write.
    task automatic write_reg(input logic sel, input logic [7:0] val);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        n_settings++;
    endtask

    // Result-side back-pressure: short stall bursts while idling is on.
    always @(negedge clk) begin
        if (stall_left != 0) begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_tready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: check the result taken at this edge against the oldest
    // expectation first, then predict the item taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        result_t got, want;
        if (!rst_n) begin
            for (int i = 0; i < ROWS; i++)
                fsm_tab[i] = '0;
            cur_state  = 8'h00;
            reject_cnt = 32'd0;
            cfg_rows   = 5'd1;
            cfg_init   = 8'h00;
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[50:0];
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual 0x%0h", $time, m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    match_field("fired", want.fired, got.fired);
                    match_field("rejected", want.rejected, got.rejected);
                    match_field("present_state", want.present_state, got.present_state);
                    match_field("action_code", want.action_code, got.action_code);
                    match_field("action_valid", want.action_valid, got.action_valid);
                    match_field("reject_total", want.reject_total, got.reject_total);
                    match_field("pad bits", 32'd0, 32'(m_tdata[55:51]));
                end
            end
            if (s_tvalid && s_tready) begin
                want = fsm_advance(s_tuser, s_tdata);
                if (drv_typed)
                    want = drv_want;
                pending_results.push_back(want);
                n_items++;
                n_fired    += want.fired;
                n_rejected += want.rejected;
                n_writes   += (s_tuser == KIND_WRITE);
            end
            if (cfg_we) begin
                if (cfg_index == CFG_ACTIVE_ROWS)
                    cfg_rows = cfg_data[4:0];
                else
                    cfg_init = cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        plan_step_t  plan [$];
        logic [7:0]  rows_cfg [NUM_PHASES];
        logic [7:0]  init_cfg [NUM_PHASES];
        int          phase_len [NUM_PHASES];
        logic [1:0]  kind;
        logic [47:0] data;
        int          roll;

        cfg_we     = 1'b0;
        cfg_index  = CFG_ACTIVE_ROWS;
        cfg_data   = 8'h00;
        s_tvalid   = 1'b0;
        s_tuser    = KIND_EVENT;
        s_tdata    = '0;
        drv_typed  = 1'b0;
        drv_want   = '0;
        idle_on    = 1'b1;
        stall_left = 0;
        errors     = 0;
        rst_n      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Reset leaves one searched row, initial state 0.
        // Row 0 is loaded before the first event so no scan reads an empty row.
        plan.push_back(do_check(KIND_WRITE, row_bits(4'd0, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1),
                                res(0, 0, 8'h00, 8'h00, 0, 0)));
        plan.push_back(do_check(KIND_EVENT, 48'h00, res(1, 0, 8'hFF, 8'hFF, 1, 0)));
        plan.push_back(do_check(KIND_EVENT, 48'hFF, res(0, 1, 8'hFF, 8'h00, 0, 1)));
        // unknown kind with every field bit set: nothing moves
        plan.push_back(do_check(KIND_SPARE, {3'b000, {45{1'b1}}}, res(0, 0, 8'hFF, 8'h00, 0, 1)));
        plan.push_back(do_check(KIND_RESET, 48'h0, res(0, 0, 8'h00, 8'h00, 0, 1)));
        // row 1 fires without an action, row 3 carries action code zero
        plan.push_back(do_item(KIND_WRITE, row_bits(4'd1, 8'h00, 8'h01, 8'h10, 8'hAA, 1'b0)));
        plan.push_back(do_item(KIND_WRITE, row_bits(4'd2, 8'h10, 8'h80, 8'hFF, 8'h01, 1'b1)));
        plan.push_back(do_item(KIND_WRITE, row_bits(4'd3, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1)));
        plan.push_back(do_cfg(CFG_ACTIVE_ROWS, 8'd4));
        plan.push_back(do_check(KIND_EVENT, 48'h01, res(1, 0, 8'h10, 8'h00, 0, 1)));
        plan.push_back(do_item(KIND_EVENT, 48'h80));
        plan.push_back(do_item(KIND_EVENT, 48'hFF));
        // rows 0 and 1 now both match; the lower one must win
        plan.push_back(do_item(KIND_WRITE, row_bits(4'd1, 8'h00, 8'h00, 8'h55, 8'h77, 1'b1)));
        plan.push_back(do_item(KIND_EVENT, 48'h00));
        plan.push_back(do_item(KIND_EVENT, 48'h00));
        // zero rows searched: even a matching event is rejected
        plan.push_back(do_cfg(CFG_ACTIVE_ROWS, 8'd0));
        plan.push_back(do_check(KIND_EVENT, 48'hFF, res(0, 1, 8'hFF, 8'h00, 0, 3)));
        plan.push_back(do_cfg(CFG_ACTIVE_ROWS, 8'd4));
        plan.push_back(do_item(KIND_EVENT, 48'hFF));
        // a new initial state only applies at the next reset item
        plan.push_back(do_cfg(CFG_INITIAL_STATE, 8'hC3));
        plan.push_back(do_item(KIND_EVENT, 48'h01));
        plan.push_back(do_check(KIND_RESET, 48'h0, res(0, 0, 8'hC3, 8'h00, 0, 4)));
        plan.push_back(do_item(KIND_EVENT, 48'h00));
        plan.push_back(do_cfg(CFG_INITIAL_STATE, 8'h00));
        plan.push_back(do_item(KIND_RESET, 48'h0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                write_reg(plan[i].cfg_sel, plan[i].cfg_val);
            else
                offer(plan[i].kind, plan[i].data, plan[i].typed, plan[i].want);
        end

        // Random phases. Row count settings cover full depth, saturation (31),
        // an 8-bit value whose low five bits give 7, zero and a single row.
        rows_cfg  = '{8'd16, 8'd31, 8'd0, 8'd1, 8'hE7, 8'd16};
        init_cfg  = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 8'h81};
        phase_len = '{120, 120, 60, 110, 120, 120};

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_ACTIVE_ROWS, rows_cfg[p]);
            write_reg(CFG_INITIAL_STATE, init_cfg[p]);
            st_pool[0] = init_cfg[p];
            st_pool[1] = (p % 2 == 1) ? 8'hFF : 8'h00;
            st_pool[2] = 8'($urandom);
            st_pool[3] = 8'($urandom);
            ev_pool[0] = (p % 2 == 1) ? 8'h00 : 8'hFF;
            ev_pool[1] = 8'($urandom);
            ev_pool[2] = 8'($urandom);
            ev_pool[3] = 8'($urandom);
            idle_on = (p != NUM_PHASES - 1);   // the closing phase runs flat out

            offer(KIND_RESET, noise(), 1'b0, '0);
            // first phase: load the rest of the table before deep scans start
            if (p == 0)
                for (int r = 4; r < ROWS; r++)
                    offer(KIND_WRITE, rand_row(4'(r)), 1'b0, '0);

            for (int k = 0; k < phase_len[p]; k++) begin
                if (p != NUM_PHASES - 1 && k % 32 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                roll = $urandom_range(0, 99);
                if (roll < 64) begin
                    kind      = KIND_EVENT;
                    data      = noise();
                    data[7:0] = pick_event();
                end else if (roll < 76) begin
                    kind = KIND_RESET;
                    data = noise();
                end else if (roll < 95) begin
                    kind = KIND_WRITE;
                    data = rand_row(4'($urandom));
                end else begin
                    kind = KIND_SPARE;
                    data = noise();
                end
                offer(kind, data, 1'b0, '0);
            end
        end

        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Ran %0d items (%0d table writes) over %0d register writes; %0d results checked.",
                 n_items, n_writes, n_settings, n_checked);
        $display("Transitions fired: %0d, events rejected: %0d, mismatches: %0d.",
                 n_fired, n_rejected, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tdsm_pkg.sv
rtl/core/tdsm_cell.sv
rtl/core/table_driven_state_machine_top.sv
tb/tb_table_driven_state_machine_top.sv
